// ===== design/lcbsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbsc_pkg: shared types and constants for the LFSR combiner byte cipher
// Generator state type, register indexes, reset seeds, LFSR step function.
// ----------------------------------------------------------------------------
package lcbsc_pkg;

    localparam int GEN_W         = 5;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = GEN_W;

    localparam logic [GEN_W-1:0] SEED_FIRST_RST  = 5'd19;
    localparam logic [GEN_W-1:0] SEED_SECOND_RST = 5'd20;
    localparam logic [GEN_W-1:0] SEED_THIRD_RST  = 5'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED_FIRST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SECOND   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_THIRD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINER_MODE = 2'd3;

    // combiner mode codes
    localparam logic MODE_GEFFE = 1'b0;
    localparam logic MODE_JK    = 1'b1;

    typedef struct packed {
        logic [GEN_W-1:0] first;
        logic [GEN_W-1:0] second;
        logic [GEN_W-1:0] third;
        logic             jk;
    } gen_state_t;

    // one step of x[n] = x[n-5] ^ x[n-2]: drop bit 0, feed bit0^bit3 into bit 4
    function automatic logic [GEN_W-1:0] lfsr_advance(input logic [GEN_W-1:0] g);
        return {g[0] ^ g[3], g[GEN_W-1:1]};
    endfunction

endpackage

// ===== design/lcbsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbsc_if: channel interfaces for the LFSR combiner byte cipher
// Input byte channel, output byte channel and configuration write channel.
// ----------------------------------------------------------------------------
interface lcbsc_in_if;
    logic                          valid;
    logic                          ready;
    logic [lcbsc_pkg::BYTE_W-1:0]  data_byte;
    logic                          restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface lcbsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [lcbsc_pkg::BYTE_W-1:0]  out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

interface lcbsc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lcbsc_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [lcbsc_pkg::CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output wr_index, output wr_data, input ready);
    modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== design/lcbsc_keygen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcbsc_keygen: eight-bit keystream from three LFSRs
// Unrolled eight generator steps; Geffe or JK combiner; first bit is the MSB.
// ----------------------------------------------------------------------------
module lcbsc_keygen
(
    input  lcbsc_pkg::gen_state_t          cur_state,
    input  logic                           mode,
    output logic [lcbsc_pkg::BYTE_W-1:0]   key,
    output lcbsc_pkg::gen_state_t          next_state
);
    import lcbsc_pkg::*;

    always_comb
    begin
        gen_state_t st;
        logic       a;
        logic       b;
        logic       c;
        logic       kb;
        st  = cur_state;
        key = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            a = st.first[0];
            b = st.second[0];
            c = st.third[0];
            st.first  = lfsr_advance(st.first);
            st.second = lfsr_advance(st.second);
            st.third  = lfsr_advance(st.third);
            if (mode == MODE_JK)
            begin
                // J = c, K = b
                st.jk = (c & ~st.jk) | (~b & st.jk);
                kb    = st.jk;
            end
            else
            begin
                kb = (a & b) ^ (~b & c);
            end
            key = {key[BYTE_W-2:0], kb};
        end
        next_state = st;
    end

endmodule

// ===== design/lfsr_combiner_byte_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_combiner_byte_stream_cipher: Geffe / JK combiner byte stream cipher
// Three 5-bit LFSRs feed a combiner; each byte is XORed with 8 key bits.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    data_byte[7:0], restart
//  out_ch    out   valid/ready    out_byte[7:0]
//  cfg       in    valid/ready    wr_index[1:0], wr_data[4:0]
//
//  One request per cycle sustained while out_ch is ready; a request passes
//  the input register, then keystream logic into the result register.
//  The eight generator steps are combinational and close on the generator registers.
//  Reset loads the default seeds, Geffe mode, clears jk and both valids.
//  A full result register stalls the input register; input ready drops
//  only when both hold a request.  cfg is always ready.
// ----------------------------------------------------------------------------
module lfsr_combiner_byte_stream_cipher
(
    input  logic              clk,
    input  logic              rst_n,
    lcbsc_in_if.sink          in_ch,
    lcbsc_out_if.source       out_ch,
    lcbsc_cfg_if.sink         cfg
);
    import lcbsc_pkg::*;

    // configuration registers
    logic [GEN_W-1:0]  seed_first_reg;
    logic [GEN_W-1:0]  seed_second_reg;
    logic [GEN_W-1:0]  seed_third_reg;
    logic              mode_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_restart_reg;

    // result register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;

    // generator state
    gen_state_t        gen_reg;
    gen_state_t        gen_start;
    gen_state_t        gen_next;
    logic [BYTE_W-1:0] key;

    logic              advance;
    logic              in_take;
    logic              cfg_take;

    // move the staged request into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_take  = in_ch.valid && in_ch.ready;
    assign cfg_take = cfg.valid && cfg.ready;

    assign in_ch.ready     = !in_valid_reg || advance;
    assign cfg.ready       = 1'b1;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;

    // restart starts this byte from the seeds with jk cleared
    always_comb
    begin
        if (in_restart_reg)
        begin
            gen_start.first  = seed_first_reg;
            gen_start.second = seed_second_reg;
            gen_start.third  = seed_third_reg;
            gen_start.jk     = 1'b0;
        end
        else
        begin
            gen_start = gen_reg;
        end
    end

    lcbsc_keygen u_keygen
    (
        .cur_state  (gen_start),
        .mode       (mode_reg),
        .key        (key),
        .next_state (gen_next)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_first_reg  <= SEED_FIRST_RST;
            seed_second_reg <= SEED_SECOND_RST;
            seed_third_reg  <= SEED_THIRD_RST;
            mode_reg        <= MODE_GEFFE;
        end
        else if (cfg_take)
        begin
            unique case (cfg.wr_index)
                REG_SEED_FIRST:    seed_first_reg  <= cfg.wr_data;
                REG_SEED_SECOND:   seed_second_reg <= cfg.wr_data;
                REG_SEED_THIRD:    seed_third_reg  <= cfg.wr_data;
                REG_COMBINER_MODE: mode_reg        <= cfg.wr_data[0];
                default:           ;
            endcase
        end
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gen_reg.first  <= SEED_FIRST_RST;
            gen_reg.second <= SEED_SECOND_RST;
            gen_reg.third  <= SEED_THIRD_RST;
            gen_reg.jk     <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                gen_reg       <= gen_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg    <= in_ch.data_byte;
            in_restart_reg <= in_ch.restart;
        end
        if (advance)
            out_byte_reg <= in_byte_reg ^ key;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("staged request lost while stalled");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request did not reach result register");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ch.ready)
        else $error("input not ready with empty input register");

    a_gen_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(gen_reg))
        else $error("generator state moved without a request");

endmodule

// ===== tb/tb_lfsr_combiner_byte_stream_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfsr_combiner_byte_stream_cipher: self-checking bench for the byte cipher
// Drives byte requests and register writes through the channel interfaces.
// A scoreboard with its own keystream generator predicts every output byte.
// ----------------------------------------------------------------------------
module tb_lfsr_combiner_byte_stream_cipher;

    import lcbsc_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps a private copy of seeds, mode, generators and the JK
    // bit, computes the cipher byte for each accepted request and queues it
    // until the block hands back its result.
    // ------------------------------------------------------------------------
    class keystream_scoreboard;
        logic [GEN_W-1:0]  seed_a, seed_b, seed_c;
        logic              mode;
        logic [GEN_W-1:0]  gen_a, gen_b, gen_c;
        logic              jk_q;
        logic [BYTE_W-1:0] cipher_q[$];
        int                errors;

        function new();
            errors = 0;
            seed_a = SEED_FIRST_RST;
            seed_b = SEED_SECOND_RST;
            seed_c = SEED_THIRD_RST;
            mode   = MODE_GEFFE;
            reload();
        endfunction

        function void reload();
            gen_a = seed_a;
            gen_b = seed_b;
            gen_c = seed_c;
            jk_q  = 1'b0;
        endfunction

        // Seeds only take effect at the next restart; mode applies at once.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SEED_FIRST:    seed_a = val;
                REG_SEED_SECOND:   seed_b = val;
                REG_SEED_THIRD:    seed_c = val;
                REG_COMBINER_MODE: mode   = val[0];
                default: ;
            endcase
        endfunction

        // Eight combiner steps, first key bit lands in the MSB.
        function logic [BYTE_W-1:0] next_key_byte();
            logic [BYTE_W-1:0] key;
            logic a, b, c, kb;
            key = '0;
            for (int k = 0; k < BYTE_W; k++)
            begin
                a = gen_a[0];
                b = gen_b[0];
                c = gen_c[0];
                gen_a = {gen_a[0] ^ gen_a[3], gen_a[GEN_W-1:1]};
                gen_b = {gen_b[0] ^ gen_b[3], gen_b[GEN_W-1:1]};
                gen_c = {gen_c[0] ^ gen_c[3], gen_c[GEN_W-1:1]};
                if (mode == MODE_JK)
                begin
                    jk_q = (c & ~jk_q) | (~b & jk_q);
                    kb   = jk_q;
                end
                else
                begin
                    kb = (a & b) ^ (~b & c);
                end
                key = {key[BYTE_W-2:0], kb};
            end
            return key;
        endfunction

        function void note_request(logic [BYTE_W-1:0] data, logic restart);
            if (restart)
                reload();
            cipher_q.push_back(data ^ next_key_byte());
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(logic [BYTE_W-1:0] out_byte);
            logic [BYTE_W-1:0] want;
            if (cipher_q.size() == 0)
            begin
                report($sformatf("out_byte %02h with no request pending", out_byte));
            end
            else
            begin
                want = cipher_q.pop_front();
                if (out_byte !== want)
                    report($sformatf("out_byte got %02h want %02h", out_byte, want));
            end
        endtask

        function int pending();
            return cipher_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    lcbsc_in_if  in_ch();
    lcbsc_out_if out_ch();
    lcbsc_cfg_if cfg();

    lfsr_combiner_byte_stream_cipher i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    keystream_scoreboard sb = new();

    // idle odds in percent, changed per phase by the main sequence
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off: main raises the flag, the receiver counts it out
    bit hold_req  = 1'b0;
    int hold_left = 0;
    localparam int HOLD_CYCLES = 64;

    localparam int N_PHASES      = 10;
    localparam int PHASE_ITEMS   = 50;
    localparam int SETTLE_CYCLES = 4;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // every block input known from time zero
    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.restart   = 1'b0;
        cfg.valid       = 1'b0;
        cfg.wr_index    = '0;
        cfg.wr_data     = '0;
        out_ch.ready    = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready changes on the falling edge; a hold-off request drops it
    // for HOLD_CYCLES in a row so the two pipeline registers fill and the
    // input side has to stall.
    // ------------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready = 1'b0;
            end
            else if (hold_req)
            begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready = 1'b0;
            end
            else
            begin
                out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // result monitor: sampled on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.out_byte);
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one byte request; valid stays high after acceptance so that the
    // next request can follow back to back.
    task automatic send_request(input logic [BYTE_W-1:0] data, input logic restart);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = data;
        in_ch.restart   = restart;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_request(data, restart);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg.valid    = 1'b1;
        cfg.wr_index = idx;
        cfg.wr_data  = val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Let the pipe empty, then reprogram all four registers. The mode value
    // may carry upper bits; only bit 0 counts.
    task automatic program_regs(input logic [GEN_W-1:0] s_a, input logic [GEN_W-1:0] s_b,
                                input logic [GEN_W-1:0] s_c, input logic [CFG_DATA_W-1:0] m);
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(REG_SEED_FIRST, s_a);
        cfg_write(REG_SEED_SECOND, s_b);
        cfg_write(REG_SEED_THIRD, s_c);
        cfg_write(REG_COMBINER_MODE, m);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // seed value: either end of the range or anything in between
    function automatic logic [GEN_W-1:0] pick_seed(input bit extreme);
        if (extreme)
            return ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
        return GEN_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit   extreme;
        logic rs;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed: reset seeds in Geffe mode, first bytes without restart
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'h5A, 1'b1);
        send_request(8'hA5, 1'b0);

        // new seeds and JK mode mid-message: seeds wait for restart, mode does not
        program_regs(5'd31, 5'd31, 5'd31, 5'h01);
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h3C, 1'b0);

        // back to Geffe mid-message: jk bit is kept
        program_regs(5'd31, 5'd31, 5'd31, 5'h00);
        send_request(8'hC3, 1'b0);

        // all-zero seeds in both modes; mode value with upper bits set
        program_regs(5'd0, 5'd0, 5'd0, 5'h1E);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        program_regs(5'd0, 5'd0, 5'd0, 5'h1F);
        send_request(8'h00, 1'b1);
        send_request(8'h77, 1'b0);

        // mixed extremes
        program_regs(5'd31, 5'd0, 5'd31, 5'h1E);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        program_regs(5'd0, 5'd31, 5'd0, 5'h01);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);

        // --- random phases: a new register setting each phase, messages
        // that mostly start with a restart and run for a dozen bytes or so
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            extreme = (ph % 3 == 0);
            program_regs(pick_seed(extreme), pick_seed(extreme), pick_seed(extreme),
                         CFG_DATA_W'($urandom_range(0, 31)));

            if (ph < 4)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 73;
            end
            else if (ph < 7)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // one long receiver stall while requests keep coming
            if (ph == 7)
                hold_req = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // first byte of a phase may skip the restart, so the new seeds
                // are seen to stay inactive until the next restart
                if (k == 0)
                    rs = 1'($urandom_range(0, 1));
                else
                    rs = ($urandom_range(0, 11) == 0);
                send_request(pick_byte(), rs);
            end
        end

        @(negedge clk);
        in_ch.valid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/lcbsc_pkg.sv
design/lcbsc_if.sv
design/lcbsc_keygen.sv
design/lfsr_combiner_byte_stream_cipher.sv
tb/tb_lfsr_combiner_byte_stream_cipher.sv
